@@ hw/rtl/rrts_pkg.sv @@
// Package with shared types, codes and sizes of the task-slot scheduler.
package rrts_pkg;

	localparam int SLOTS_DEF    = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam logic [2:0] FN_CREATE   = 3'd0;
	localparam logic [2:0] FN_RESUME   = 3'd1;
	localparam logic [2:0] FN_WAIT     = 3'd2;
	localparam logic [2:0] FN_WAKE     = 3'd3;
	localparam logic [2:0] FN_KILL     = 3'd4;
	localparam logic [2:0] FN_DETACH   = 3'd5;
	localparam logic [2:0] FN_SCHEDULE = 3'd6;

	localparam logic [3:0] WT_NONE   = 4'd0;
	localparam logic [3:0] WT_TOTAL  = 4'd1;
	localparam logic [3:0] WT_TASK   = 4'd2;
	localparam logic [3:0] WT_WM     = 4'd7;
	localparam logic [3:0] WT_TIMER  = 4'd8;
	localparam logic [3:0] WT_ZOMBIE = 4'd9;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NO_TASK = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [5:0]  slot;
		logic [3:0]  wait_type;
		logic [31:0] wait_key;
		logic [31:0] tick_now;
	} rrts_in_t;

	typedef struct packed {
		logic [5:0] chosen_slot;
		logic [1:0] status;
		logic [5:0] woken_count;
	} rrts_out_t;

endpackage

@@ hw/rtl/round_robin_task_slot_scheduler.sv @@
// Top level of the round-robin task-slot scheduler: slot table and sweep sequencer.
// Resume, wait, detach and unused codes go from acceptance straight to the finish state;
// create sweeps slot 1 upward, one slot per cycle; wake, kill and schedule take each
// slot in a read phase and a compare phase because the key store is read through a register.
// A new item is taken only after the result leaves; in_stall is high until then.
// Reset (asynchronous, active low) empties the table at once: kernel runs, scan limit is one.
module round_robin_task_slot_scheduler #(
	parameter int SLOTS    = rrts_pkg::SLOTS_DEF,
	parameter int KEY_BITS = rrts_pkg::KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rrts_pkg::rrts_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rrts_pkg::rrts_out_t out_data
);
	import rrts_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int LW = SW + 1;

	typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_SCHED2, S_FINISH, S_OUT} state_t;

	// Per-slot state bits live in flip-flops that reset clears; the key store does not.
	logic [SLOTS-1:0] exists_q, susp_q, att_q;
	logic [3:0]       wtype_q [SLOTS];
	logic [KEY_BITS-1:0] key_mem [SLOTS];
	logic [KEY_BITS-1:0] key_rd_q;   // registered read of the key store at idx_q

	state_t     state_q;
	rrts_in_t   item_q;
	logic [SW-1:0] idx_q;      // slot under the sweep
	logic          ph_q;       // compare phase of a slot step, after its key read
	logic [SW-1:0] run_q;      // running slot
	logic [LW-1:0] lim_q;      // scan limit
	logic [SW-1:0] found_q;    // result of a search
	logic          hit_q;
	logic [5:0]    woken_q;
	logic [LW-1:0] hi_q;       // highest existing or chosen slot plus one seen by the create sweep
	rrts_out_t     res_q;

	logic [SW-1:0] slot_i;
	logic          slot_ok;
	logic [3:0]    ref_type;
	logic [KEY_BITS-1:0] ref_key;
	logic          rel_hit, run_hit;
	logic [LW-1:0] idx_ext, lim_eff;

	function automatic rrts_out_t mk_res(input logic [5:0] c, input logic [1:0] st,
			input logic [5:0] w);
		rrts_out_t r;
		r.chosen_slot = c;
		r.status      = st;
		r.woken_count = w;
		return r;
	endfunction

	assign slot_ok = (SLOTS >= 64 || 32'(item_q.slot) < 32'(SLOTS)) && item_q.slot != 6'd0
		&& exists_q[slot_i];
	assign slot_i  = SW'(item_q.slot);
	assign idx_ext = LW'(idx_q);
	assign lim_eff = (32'(lim_q) > 32'(SLOTS)) ? LW'(SLOTS) : lim_q;
	assign ref_type = (item_q.func == FN_KILL) ? WT_TASK : item_q.wait_type;
	assign ref_key  = (item_q.func == FN_KILL) ? KEY_BITS'(item_q.slot)
		: KEY_BITS'({{(KEY_BITS > 32 ? KEY_BITS-32 : 1){1'b0}}, item_q.wait_key});

	// Only a wake of type wm ignores the key; kill always matches on the slot number.
	rrts_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
		.exists(exists_q[idx_q]), .susp(susp_q[idx_q]), .wtype(wtype_q[idx_q]),
		.key(key_rd_q), .ref_type(ref_type), .ref_key(ref_key),
		.any_key(item_q.func == FN_WAKE && item_q.wait_type == WT_WM),
		.tick(item_q.tick_now),
		.release_hit(rel_hit), .run_hit(run_hit)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	// Key store: written only by create and wait, read through a register.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && item_q.func == FN_CREATE && hit_q)
			key_mem[found_q] <= '0;
		else if (state_q == S_FINISH && item_q.func == FN_WAIT && slot_ok)
			key_mem[slot_i] <= KEY_BITS'(item_q.wait_key);
		key_rd_q <= key_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			exists_q <= '0;
			susp_q   <= '0;
			att_q    <= '0;
			for (int i = 0; i < SLOTS; i++) wtype_q[i] <= WT_NONE;
			run_q    <= '0;
			lim_q    <= LW'(1);
			idx_q    <= '0;
			ph_q     <= 1'b0;
			found_q  <= '0;
			hit_q    <= 1'b0;
			woken_q  <= '0;
			hi_q     <= LW'(1);
			item_q   <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						hit_q   <= 1'b0;
						woken_q <= '0;
						found_q <= '0;
						hi_q    <= LW'(1);
						ph_q    <= 1'b0;
						if (in_data.func == FN_SCHEDULE) begin
							if (run_q == '0 || (LW'(run_q) + LW'(1) < lim_eff
								&& 32'(run_q) + 1 < SLOTS)) begin
								idx_q   <= (run_q == '0) ? '0 : SW'(LW'(run_q) + LW'(1));
								state_q <= S_SWEEP;
							end else begin
								idx_q   <= '0;
								state_q <= S_SCHED2;
							end
						end else if (in_data.func == FN_CREATE || in_data.func == FN_KILL
							|| in_data.func == FN_WAKE) begin
							idx_q   <= (in_data.func == FN_CREATE) ? SW'(1) : '0;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SWEEP: begin
					if (!ph_q && item_q.func != FN_CREATE) begin
						// First cycle of a slot: its key is being read into key_rd_q.
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						// One slot per step through the shared compare unit.
						case (item_q.func)
							FN_CREATE: begin
								if (exists_q[idx_q]) hi_q <= idx_ext + LW'(1);
								if (!exists_q[idx_q] && !hit_q) begin
									hit_q   <= 1'b1;
									found_q <= idx_q;
									if (idx_ext + LW'(1) > hi_q) hi_q <= idx_ext + LW'(1);
								end
								if (32'(idx_q) == SLOTS - 1) state_q <= S_FINISH;
								else idx_q <= idx_q + SW'(1);
							end
							FN_WAKE, FN_KILL: begin
								if (rel_hit && !(item_q.func == FN_KILL && !slot_ok)
									&& !(item_q.func == FN_WAKE
									&& (item_q.wait_type == WT_NONE
									|| item_q.wait_type == WT_ZOMBIE))) begin
									susp_q[idx_q]  <= 1'b0;
									wtype_q[idx_q] <= WT_NONE;
									if (woken_q != 6'd63) woken_q <= woken_q + 6'd1;
								end
								if (32'(idx_q) == SLOTS - 1) state_q <= S_FINISH;
								else idx_q <= idx_q + SW'(1);
							end
							FN_SCHEDULE: begin
								if (run_hit) begin
									if (wtype_q[idx_q] != WT_NONE) begin
										susp_q[idx_q]  <= 1'b0;
										wtype_q[idx_q] <= WT_NONE;
									end
									hit_q   <= 1'b1;
									found_q <= idx_q;
									state_q <= S_FINISH;
								end else if (idx_ext + LW'(1) >= lim_eff) begin
									idx_q   <= '0;
									state_q <= S_SCHED2;
								end else begin
									idx_q <= idx_q + SW'(1);
								end
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SCHED2: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						// Wrapped part: slots below the running one.
						if (idx_q >= run_q) begin
							state_q <= S_FINISH;
						end else if (run_hit) begin
							if (wtype_q[idx_q] != WT_NONE) begin
								susp_q[idx_q]  <= 1'b0;
								wtype_q[idx_q] <= WT_NONE;
							end
							hit_q   <= 1'b1;
							found_q <= idx_q;
							state_q <= S_FINISH;
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
				end
				S_FINISH: begin
					case (item_q.func)
						FN_CREATE: begin
							if (hit_q) begin
								exists_q[found_q] <= 1'b1;
								susp_q[found_q]   <= 1'b1;
								wtype_q[found_q]  <= WT_TOTAL;
								att_q[found_q]    <= 1'b1;
								lim_q <= hi_q;
								res_q <= mk_res(6'(found_q), ST_OK, 6'd0);
							end else begin
								res_q <= mk_res(6'd0, ST_FULL, 6'd0);
							end
						end
						FN_RESUME: begin
							if (slot_ok) begin
								susp_q[slot_i]  <= 1'b0;
								wtype_q[slot_i] <= WT_NONE;
								res_q <= mk_res(6'd0, ST_OK, 6'd0);
							end else res_q <= mk_res(6'd0, ST_NO_TASK, 6'd0);
						end
						FN_WAIT: begin
							if (slot_ok) begin
								susp_q[slot_i]  <= 1'b1;
								wtype_q[slot_i] <= item_q.wait_type;
								res_q <= mk_res(6'd0, ST_OK, 6'd0);
							end else res_q <= mk_res(6'd0, ST_NO_TASK, 6'd0);
						end
						FN_WAKE: res_q <= mk_res(6'd0, ST_OK, woken_q);
						FN_KILL: begin
							if (slot_ok) begin
								res_q <= mk_res(6'd0, ST_OK, woken_q);
								if (run_q == slot_i) run_q <= '0;
								if (att_q[slot_i]) begin
									susp_q[slot_i]  <= 1'b1;
									wtype_q[slot_i] <= WT_ZOMBIE;
								end else exists_q[slot_i] <= 1'b0;
							end else res_q <= mk_res(6'd0, ST_NO_TASK, 6'd0);
						end
						FN_DETACH: begin
							if (slot_ok) begin
								att_q[slot_i] <= 1'b0;
								res_q <= mk_res(6'd0, ST_OK, 6'd0);
							end else res_q <= mk_res(6'd0, ST_NO_TASK, 6'd0);
						end
						FN_SCHEDULE: begin
							run_q <= hit_q ? found_q : '0;
							res_q <= mk_res(hit_q ? 6'(found_q) : 6'd0, ST_OK, 6'd0);
						end
						default: res_q <= mk_res(6'd0, ST_OK, 6'd0);
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/rrts_cmp.sv @@
// Shared compare unit: combinationally judges the slot entry under the running sweep.
module rrts_cmp #(
	parameter int KEY_BITS = rrts_pkg::KEY_BITS_DEF
) (
	input  logic                exists,
	input  logic                susp,
	input  logic [3:0]          wtype,
	input  logic [KEY_BITS-1:0] key,
	input  logic [3:0]          ref_type,
	input  logic [KEY_BITS-1:0] ref_key,
	input  logic                any_key,
	input  logic [31:0]         tick,
	output logic                release_hit,
	output logic                run_hit
);
	import rrts_pkg::*;

	logic tick_gt;

	always_comb begin
		if (KEY_BITS > 32)
			tick_gt = {{(KEY_BITS > 32 ? KEY_BITS-32 : 1){1'b0}}, tick} > key;
		else
			tick_gt = tick > 32'(key);
	end

	assign release_hit = exists && susp && (wtype == ref_type) && (any_key || key == ref_key);

	always_comb begin
		if (!exists)
			run_hit = 1'b0;
		else if (wtype == WT_NONE)
			run_hit = 1'b1;
		else if (wtype == WT_TIMER)
			run_hit = tick_gt;
		else
			run_hit = !susp;
	end
endmodule

@@ hw/rtl/rrts_checker.sv @@
// Port-level checker of the task-slot scheduler and its bind.
module rrts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input rrts_pkg::rrts_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input rrts_pkg::rrts_out_t out_data
);
	import rrts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second item while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");

	a_no_out_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result shown while ready for input");
endmodule

bind round_robin_task_slot_scheduler rrts_checker u_rrts_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the round-robin task-slot scheduler.
`timescale 1ns / 100ps

module testbench;
	import rrts_pkg::*;

	localparam int NSLOT = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [2:0] FN_SPARE = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	rrts_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	rrts_out_t out_data;

	round_robin_task_slot_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// The clock runs with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Shadow copy of the slot table, advanced once for every accepted item.
	logic        tbl_exists [NSLOT];
	logic        tbl_susp [NSLOT];
	logic [3:0]  tbl_wtype [NSLOT];
	logic [31:0] tbl_wkey [NSLOT];
	logic        tbl_attached [NSLOT];
	int          cur_running;
	int          cur_limit;

	rrts_in_t  pending_items[$];
	rrts_out_t expected_results[$];
	int        error_count;
	bit        hold_off_req;
	bit        hold_used;
	bit        in_taken;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Revive clears suspension and returns the slot to wait type none.
	function automatic void revive_slot(input int s);
		tbl_susp[s] = 1'b0;
		tbl_wtype[s] = WT_NONE;
	endfunction

	// A timer wait becomes runnable only once the tick is strictly past its key;
	// other waits become runnable when their suspension has been cleared.
	function automatic bit slot_ready(input int s, input logic [31:0] tick);
		if (tbl_wtype[s] == WT_NONE) return 1'b1;
		if (tbl_wtype[s] == WT_TIMER) begin
			if (tick > tbl_wkey[s]) begin
				revive_slot(s);
				return 1'b1;
			end
			return 1'b0;
		end
		if (!tbl_susp[s]) begin
			revive_slot(s);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int release_waiters(input logic [3:0] wt, input logic [31:0] key,
			input bit any_key);
		int n;
		n = 0;
		for (int s = 0; s < NSLOT; s++) begin
			if (!tbl_exists[s] || !tbl_susp[s] || tbl_wtype[s] != wt) continue;
			if (!any_key && tbl_wkey[s] != key) continue;
			revive_slot(s);
			if (n < 63) n++;
		end
		return n;
	endfunction

	function automatic bit slot_has_task(input int s);
		return s != 0 && tbl_exists[s];
	endfunction

	// Works out the result of one item and updates the shadow table.
	function automatic rrts_out_t schedule_outcome(input rrts_in_t it);
		rrts_out_t r;
		int s, pick, lim;
		bit found;
		r = '0;
		s = int'(it.slot);
		case (it.func)
			FN_CREATE: begin
				pick = 0;
				for (int k = 1; k < NSLOT; k++)
					if (!tbl_exists[k]) begin
						pick = k;
						break;
					end
				if (pick == 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_exists[pick] = 1'b1;
					tbl_susp[pick] = 1'b1;
					tbl_wtype[pick] = WT_TOTAL;
					tbl_wkey[pick] = '0;
					tbl_attached[pick] = 1'b1;
					r.chosen_slot = 6'(pick);
					cur_limit = 1;
					for (int k = NSLOT - 1; k > 0; k--)
						if (tbl_exists[k]) begin
							cur_limit = k + 1;
							break;
						end
				end
			end
			FN_RESUME: begin
				if (!slot_has_task(s)) r.status = ST_NO_TASK;
				else revive_slot(s);
			end
			FN_WAIT: begin
				if (!slot_has_task(s)) begin
					r.status = ST_NO_TASK;
				end else begin
					tbl_wtype[s] = it.wait_type;
					tbl_wkey[s] = it.wait_key;
					tbl_susp[s] = 1'b1;
				end
			end
			FN_WAKE: begin
				if (it.wait_type != WT_NONE && it.wait_type != WT_ZOMBIE)
					r.woken_count = 6'(release_waiters(it.wait_type, it.wait_key,
						it.wait_type == WT_WM));
			end
			FN_KILL: begin
				if (!slot_has_task(s)) begin
					r.status = ST_NO_TASK;
				end else begin
					r.woken_count = 6'(release_waiters(WT_TASK, 32'(s), 1'b0));
					if (cur_running == s) cur_running = 0;
					if (tbl_attached[s]) begin
						tbl_susp[s] = 1'b1;
						tbl_wtype[s] = WT_ZOMBIE;
					end else begin
						tbl_exists[s] = 1'b0;
					end
				end
			end
			FN_DETACH: begin
				if (!slot_has_task(s)) r.status = ST_NO_TASK;
				else tbl_attached[s] = 1'b0;
			end
			FN_SCHEDULE: begin
				// Scan after the running slot up to the limit, then wrap below it.
				found = 1'b0;
				pick = 0;
				lim = cur_limit > NSLOT ? NSLOT : cur_limit;
				for (int k = (cur_running == 0) ? 0 : cur_running + 1; k < lim && !found; k++)
					if (tbl_exists[k] && slot_ready(k, it.tick_now)) begin
						pick = k;
						found = 1'b1;
					end
				for (int k = 0; k < cur_running && !found; k++)
					if (tbl_exists[k] && slot_ready(k, it.tick_now)) begin
						pick = k;
						found = 1'b1;
					end
				cur_running = found ? pick : 0;
				r.chosen_slot = 6'(cur_running);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: bursts of items with random gaps, payload held while stalled.
	// An item taken at the last rising edge is replaced here or valid drops.
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Acceptance at the rising edge feeds the predictor and tells the driver.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_results.push_back(schedule_outcome(in_data));
	end

	// Receiver stall pattern, with one long hold-off on request.
	int stall_mode;
	int hold_cnt;
	always @(negedge clk) begin
		if (hold_off_req && !hold_used && hold_cnt == 0) begin
			hold_cnt <= 3000;
			hold_used <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= (hold_cnt != 1);
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Monitor: compares each accepted result with the oldest expectation.
	rrts_out_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report("unexpected result", 32'(out_data.chosen_slot), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.chosen_slot !== want.chosen_slot)
					report("chosen_slot", 32'(out_data.chosen_slot), 32'(want.chosen_slot));
				if (out_data.status !== want.status)
					report("status", 32'(out_data.status), 32'(want.status));
				if (out_data.woken_count !== want.woken_count)
					report("woken_count", 32'(out_data.woken_count), 32'(want.woken_count));
			end
		end
	end

	// Watchdog on cycles in which no item moves on either side.
	int idle_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[round_robin_task_slot_scheduler] ERROR");
			$finish;
		end
	end

	function automatic rrts_in_t make_item(input logic [2:0] f, input int s,
			input logic [3:0] wt, input logic [31:0] key, input logic [31:0] tick);
		rrts_in_t it;
		it.func = f;
		it.slot = 6'(s);
		it.wait_type = wt;
		it.wait_key = key;
		it.tick_now = tick;
		return it;
	endfunction

	// Keys mostly come from a small pool so that waits and wakes meet.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 63);
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	function automatic rrts_in_t random_item();
		int r;
		logic [2:0] f;
		r = $urandom_range(0, 99);
		if (r < 12) f = FN_CREATE;
		else if (r < 24) f = FN_RESUME;
		else if (r < 42) f = FN_WAIT;
		else if (r < 56) f = FN_WAKE;
		else if (r < 64) f = FN_KILL;
		else if (r < 70) f = FN_DETACH;
		else if (r < 97) f = FN_SCHEDULE;
		else f = FN_SPARE;
		return make_item(f, ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 63))
			: int'($urandom_range(0, 12)), 4'($urandom_range(0, 15)), pick_key(),
			($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 12));
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		error_count = 0;
		hold_off_req = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		hold_cnt = 0;
		idle_cycles = 0;
		cur_running = 0;
		cur_limit = 1;
		for (int k = 0; k < NSLOT; k++) begin
			tbl_exists[k] = 1'b0;
			tbl_susp[k] = 1'b0;
			tbl_wtype[k] = WT_NONE;
			tbl_wkey[k] = '0;
			tbl_attached[k] = 1'b0;
		end

		// Directed part: no-task cases, empty schedule, a few tasks run through
		// every operation, timer revive edges, wm wake, kill releasing task waiters.
		pending_items.push_back(make_item(FN_RESUME, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_KILL, 63, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_SCHEDULE, 0, WT_NONE, 0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(FN_CREATE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_CREATE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_CREATE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_SCHEDULE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_RESUME, 1, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_WAIT, 2, WT_TIMER, 32'hFFFF_FFFE, 0));
		pending_items.push_back(make_item(FN_WAIT, 3, WT_TASK, 1, 0));
		pending_items.push_back(make_item(FN_SCHEDULE, 0, WT_NONE, 0, 32'hFFFF_FFFE));
		pending_items.push_back(make_item(FN_SCHEDULE, 0, WT_NONE, 0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(FN_WAIT, 2, WT_WM, 32'h1234_5678, 0));
		pending_items.push_back(make_item(FN_WAKE, 0, WT_WM, 0, 0));
		pending_items.push_back(make_item(FN_WAIT, 2, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_WAKE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_WAKE, 0, WT_ZOMBIE, 0, 0));
		pending_items.push_back(make_item(FN_KILL, 1, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_DETACH, 2, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_KILL, 2, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_SCHEDULE, 0, WT_NONE, 0, 0));
		pending_items.push_back(make_item(FN_SPARE, 63, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// Fill the table to the top so that create reports a full table.
		for (int k = 0; k < 64; k++)
			pending_items.push_back(make_item(FN_CREATE, 0, WT_NONE, 0, 0));
		for (int k = 0; k < 1450; k++)
			pending_items.push_back(random_item());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Hold the receiver off for a long while as items keep arriving.
		repeat (400) @(posedge clk);
		hold_off_req = 1'b1;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("[round_robin_task_slot_scheduler] OK");
		else
			$display("[round_robin_task_slot_scheduler] ERROR");
		$finish;
	end

endmodule
